[sv/lzwc_pkg.sv]
// Shared constants and types for the LZW compressor with packed 12-bit codes.
// No dependencies; compiled before every other file of the block.
package lzwc_pkg;

  localparam int CODE_WIDTH_DEF   = 12;
  localparam int DICT_ENTRIES_DEF = 4096;
  localparam int BYTE_W           = 8;
  localparam int FIRST_FREE       = 256;

  // Width of the stream tag kept in each hash slot; tag zero means empty.
  localparam int EPOCH_W          = 4;

  // Control for one code beat from the dictionary engine to the bit packer.
  typedef struct packed {
    logic valid;
    logic last;
  } code_ctl_t;

endpackage

[sv/lzwc_in_if.sv]
// Input channel of the LZW compressor: one raw byte per beat plus end-of-stream flag.
// Stand-alone; no package dependency.
interface lzwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

[sv/lzwc_out_if.sv]
// Output channel of the LZW compressor: one packed code-stream byte per beat.
// Stand-alone; no package dependency.
interface lzwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       stream_end;

  modport source (output valid, output packed_byte, output stream_end, input ready);
  modport sink   (input valid, input packed_byte, input stream_end, output ready);
endinterface

[sv/lzwc_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/lzwc_packer.sv]
// Bit packer: appends fixed-width codes MSB-first and hands out whole bytes.
// Depends on lzwc_pkg and lzwc_out_if.
module lzwc_packer #(
  parameter int CODE_WIDTH = lzwc_pkg::CODE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lzwc_pkg::code_ctl_t   code_ctl,
  input  logic [CODE_WIDTH-1:0] code,
  output logic                  code_ready,
  lzwc_out_if.source            byte_out
);
  import lzwc_pkg::*;

  localparam int BUF_W = CODE_WIDTH + BYTE_W - 1;
  localparam int CNT_W = $clog2(BUF_W + 1);
  localparam logic [CNT_W-1:0] BYTE_CNT = CNT_W'(BYTE_W);

  logic [BUF_W-1:0] bits;
  logic [CNT_W-1:0] count;
  logic             last_pend;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_end;

  logic       out_free;
  logic       have_byte;
  logic       have_pad;
  logic [7:0] full_byte;
  logic [7:0] pad_byte;

  assign out_free   = !out_valid || byte_out.ready;
  assign have_byte  = count >= BYTE_CNT;
  assign have_pad   = last_pend && (count != '0) && (count < BYTE_CNT);
  assign code_ready = (count < BYTE_CNT) && !last_pend;

  // Bits above the fill count are stale; both extractions push them out.
  assign full_byte = 8'(bits >> (count - BYTE_CNT));
  assign pad_byte  = bits[7:0] << (BYTE_CNT - count);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      last_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free && have_byte) begin
        out_valid <= 1'b1;
        out_byte  <= full_byte;
        out_end   <= last_pend && (count == BYTE_CNT);
        count     <= count - BYTE_CNT;
        if (count == BYTE_CNT) begin
          last_pend <= 1'b0;
        end
      end else if (out_free && have_pad) begin
        out_valid <= 1'b1;
        out_byte  <= pad_byte;
        out_end   <= 1'b1;
        count     <= '0;
        last_pend <= 1'b0;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (code_ctl.valid && code_ready) begin
        bits      <= (bits << CODE_WIDTH) | BUF_W'(code);
        count     <= count + CNT_W'(CODE_WIDTH);
        last_pend <= code_ctl.last;
      end
    end
  end

  assign byte_out.valid       = out_valid;
  assign byte_out.packed_byte = out_byte;
  assign byte_out.stream_end  = out_end;

endmodule

[sv/lzw_compressor_12bit_packed_core.sv]
// LZW compressor core: hashed dictionary in one RAM, codes packed MSB-first into bytes.
// Depends on lzwc_pkg, lzwc_in_if, lzwc_out_if, lzwc_ram and lzwc_packer.
//
//   Port      | Dir | Beat contents
//   ----------+-----+------------------------------------------------------
//   byte_in   | in  | data_byte (8 bits), final_byte (1 = last byte of stream)
//   byte_out  | out | packed_byte (8 bits), stream_end (1 = last byte of stream)
//
// A byte that starts a stream is taken in ST_IDLE alone; any other byte then goes
// through ST_PROBE, one probe per slot (linear probing in the single dictionary RAM,
// registered read). A byte that misses the dictionary passes ST_EMIT_MISS to hand its
// code to the packer, and a final byte passes ST_EMIT_FINAL for the closing code.
// After reset, and after every fifteenth stream, a clearing pass writes all
// 2*DICT_ENTRIES slots while byte_in is not ready.
// A code hand-off waits while the packer holds a full byte or more of pending bits
// or an unsent stream end, so a stalled byte_out holds byte_in not ready.
module lzw_compressor_12bit_packed_core #(
  parameter int CODE_WIDTH   = lzwc_pkg::CODE_WIDTH_DEF,
  parameter int DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lzwc_in_if.sink    byte_in,
  lzwc_out_if.source byte_out
);
  import lzwc_pkg::*;

  localparam int IDX_W   = $clog2(DICT_ENTRIES);
  localparam int SLOT_W  = IDX_W + 1;
  localparam int SLOTS   = 1 << SLOT_W;
  localparam int ENTRY_W = EPOCH_W + IDX_W + BYTE_W + IDX_W;
  localparam int NF_W    = IDX_W + 1;

  localparam logic [NF_W-1:0]    NF_FIRST = NF_W'(FIRST_FREE);
  localparam logic [NF_W-1:0]    NF_LIMIT = NF_W'(DICT_ENTRIES);
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_EMIT_MISS,
    ST_EMIT_FINAL
  } state_t;

  state_t              state;
  logic [SLOT_W-1:0]   clr_addr;
  logic [EPOCH_W-1:0]  epoch;
  logic [NF_W-1:0]     next_free;
  logic [IDX_W-1:0]    prefix;
  logic                prefix_valid;
  logic [BYTE_W-1:0]   cur_byte;
  logic                cur_final;
  logic [SLOT_W-1:0]   probe_addr;

  logic                ram_wr_en;
  logic [SLOT_W-1:0]   ram_wr_addr;
  logic [ENTRY_W-1:0]  ram_wr_data;
  logic                ram_rd_en;
  logic [SLOT_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0]  ram_rd_data;

  logic [EPOCH_W-1:0]  slot_tag;
  logic [IDX_W-1:0]    slot_prefix;
  logic [BYTE_W-1:0]   slot_byte;
  logic [IDX_W-1:0]    slot_code;
  logic                occupied;
  logic                hit;
  logic                room;
  logic                accept;
  logic [SLOT_W-1:0]   in_hash;

  code_ctl_t           code_ctl;
  logic [CODE_WIDTH-1:0] code;
  logic                code_ready;

  function automatic logic [SLOT_W-1:0] slot_hash(input logic [IDX_W-1:0] p,
                                                  input logic [BYTE_W-1:0] b);
    slot_hash = SLOT_W'(p) ^ (SLOT_W'(b) << (SLOT_W - BYTE_W));
  endfunction

  // Slot layout, high to low: stream tag, prefix code, byte, assigned code.
  assign slot_code   = ram_rd_data[IDX_W-1:0];
  assign slot_byte   = ram_rd_data[IDX_W +: BYTE_W];
  assign slot_prefix = ram_rd_data[IDX_W+BYTE_W +: IDX_W];
  assign slot_tag    = ram_rd_data[2*IDX_W+BYTE_W +: EPOCH_W];

  assign occupied = slot_tag == epoch;
  assign hit      = occupied && (slot_prefix == prefix) && (slot_byte == cur_byte);
  assign room     = next_free < NF_LIMIT;
  assign in_hash  = slot_hash(prefix, byte_in.data_byte);

  assign byte_in.ready = state == ST_IDLE;
  assign accept        = byte_in.valid && byte_in.ready;

  // The engine is strictly sequential, so a slot written on a miss is never
  // read back before the following cycle.
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = probe_addr + SLOT_W'(1);
    ram_wr_en   = 1'b0;
    ram_wr_addr = probe_addr;
    ram_wr_data = {epoch, prefix, cur_byte, next_free[IDX_W-1:0]};
    case (state)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
      end
      ST_IDLE: begin
        ram_rd_en   = accept && prefix_valid;
        ram_rd_addr = in_hash;
      end
      ST_PROBE: begin
        ram_rd_en = occupied && !hit;
        ram_wr_en = !occupied && room;
      end
      default: begin
      end
    endcase
  end

  assign code_ctl.valid = (state == ST_EMIT_MISS) || (state == ST_EMIT_FINAL);
  assign code_ctl.last  = state == ST_EMIT_FINAL;
  assign code           = CODE_WIDTH'(prefix);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      epoch        <= EPOCH_FIRST;
      next_free    <= NF_FIRST;
      prefix       <= '0;
      prefix_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + SLOT_W'(1);
          if (clr_addr == SLOT_W'(SLOTS - 1)) begin
            epoch <= EPOCH_FIRST;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cur_byte  <= byte_in.data_byte;
            cur_final <= byte_in.final_byte;
            if (!prefix_valid) begin
              prefix       <= IDX_W'(byte_in.data_byte);
              prefix_valid <= 1'b1;
              state        <= byte_in.final_byte ? ST_EMIT_FINAL : ST_IDLE;
            end else begin
              probe_addr <= in_hash;
              state      <= ST_PROBE;
            end
          end
        end
        ST_PROBE: begin
          if (hit) begin
            prefix <= slot_code;
            state  <= cur_final ? ST_EMIT_FINAL : ST_IDLE;
          end else if (occupied) begin
            probe_addr <= probe_addr + SLOT_W'(1);
          end else begin
            if (room) begin
              next_free <= next_free + NF_W'(1);
            end
            state <= ST_EMIT_MISS;
          end
        end
        ST_EMIT_MISS: begin
          if (code_ready) begin
            prefix <= IDX_W'(cur_byte);
            state  <= cur_final ? ST_EMIT_FINAL : ST_IDLE;
          end
        end
        ST_EMIT_FINAL: begin
          if (code_ready) begin
            prefix       <= '0;
            prefix_valid <= 1'b0;
            next_free    <= NF_FIRST;
            // Each stream gets a fresh tag; when the tags run out, wipe the table.
            if (epoch == '1) begin
              clr_addr <= '0;
              state    <= ST_CLEAR;
            end else begin
              epoch <= epoch + EPOCH_W'(1);
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  lzwc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_dict (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lzwc_packer #(
    .CODE_WIDTH (CODE_WIDTH)
  ) u_packer (
    .clk        (clk),
    .rst        (rst),
    .code_ctl   (code_ctl),
    .code       (code),
    .code_ready (code_ready),
    .byte_out   (byte_out)
  );

  a_next_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= NF_LIMIT)
    else $error("next free code ran past the dictionary size");

  a_insert_advances: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE && !occupied && room) |=> next_free == $past(next_free) + NF_W'(1))
    else $error("dictionary insert did not advance the next free code");

  a_prefix_known: assert property (@(posedge clk) disable iff (rst)
    prefix_valid |-> (NF_W'(prefix) < next_free))
    else $error("current prefix is not a code of the dictionary");

  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CLEAR) |-> (epoch != '0))
    else $error("stream tag zero would match cleared slots");

  a_probe_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && prefix_valid) |=> state == ST_PROBE)
    else $error("accepted byte with a prefix did not start a probe");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench for the LZW compressor core with 12-bit codes packed MSB-first into bytes.
// Depends on lzwc_pkg, lzwc_in_if, lzwc_out_if and lzw_compressor_12bit_packed_core.
// Predicts the packed byte stream per input beat and checks each output beat in order.
module tb;
  import lzwc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_PRINTED = 100;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_beat_t;

  logic clk;
  logic rst;

  lzwc_in_if  byte_in_if ();
  lzwc_out_if byte_out_if ();

  lzw_compressor_12bit_packed_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in_if),
    .byte_out(byte_out_if)
  );

  // Predicted compressor state.
  packed_beat_t                  expected_bytes[$];
  int unsigned                   pair_to_code[bit [CODE_WIDTH_DEF+BYTE_W-1:0]];
  int unsigned                   next_code;
  logic [CODE_WIDTH_DEF-1:0]     prefix_code;
  bit                            prefix_valid;
  int unsigned                   spill_bits;
  int unsigned                   spill_len;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned beat_index;
  int unsigned cycle_count;

  function automatic void clear_dictionary();
    pair_to_code.delete();
    next_code    = FIRST_FREE;
    prefix_code  = '0;
    prefix_valid = 1'b0;
    spill_bits   = 0;
    spill_len    = 0;
  endfunction

  // Appends one predicted beat at the tail of the expected stream.
  function automatic void queue_expected(input packed_beat_t beat);
    expected_bytes.insert(expected_bytes.size(), beat);
  endfunction

  // Appends one code to the bit stream and queues every byte it completes.
  function automatic void pack_code(input logic [CODE_WIDTH_DEF-1:0] code);
    int unsigned  acc;
    int unsigned  len;
    packed_beat_t beat;
    acc = (spill_bits << CODE_WIDTH_DEF) | 32'(code);
    len = spill_len + CODE_WIDTH_DEF;
    while (len >= BYTE_W) begin
      beat.data = BYTE_W'(acc >> (len - BYTE_W));
      beat.last = 1'b0;
      queue_expected(beat);
      len -= BYTE_W;
      acc &= (32'd1 << len) - 1;
    end
    spill_bits = acc;
    spill_len  = len;
  endfunction

  function automatic void predict_packed_bytes(input logic [BYTE_W-1:0] b, input logic fin);
    bit [CODE_WIDTH_DEF+BYTE_W-1:0] key;
    packed_beat_t                   beat;
    key = {prefix_code, b};
    if (!prefix_valid) begin
      prefix_code  = CODE_WIDTH_DEF'(b);
      prefix_valid = 1'b1;
    end else if (pair_to_code.exists(key)) begin
      prefix_code = CODE_WIDTH_DEF'(pair_to_code[key]);
    end else begin
      pack_code(prefix_code);
      // Once the dictionary is full, missing pairs are only emitted.
      if (next_code < DICT_ENTRIES_DEF) begin
        pair_to_code[key] = next_code;
        next_code++;
      end
      prefix_code = CODE_WIDTH_DEF'(b);
    end
    if (fin) begin
      pack_code(prefix_code);
      if (spill_len != 0) begin
        beat.data = BYTE_W'(spill_bits << (BYTE_W - spill_len));
        beat.last = 1'b0;
        queue_expected(beat);
      end
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
      clear_dictionary();
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("tb: output beat %0d %s: got %0h, expected %0h", beat_index, what, got, want);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_in_if.valid <= 1'b0;
      @(negedge clk);
    end
    byte_in_if.valid      <= 1'b1;
    byte_in_if.data_byte  <= b;
    byte_in_if.final_byte <= fin;
    do @(posedge clk); while (!byte_in_if.ready);
    @(negedge clk);
    predict_packed_bytes(b, fin);
  endtask

  task automatic test_single_byte_streams();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_two_byte_stream();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // A run of one byte keeps extending the prefix through ever longer strings.
  task automatic test_repeated_byte();
    for (int i = 0; i < 8; i++) send_byte(8'h41, i == 7);
  endtask

  // Sent twice: the second stream must start from a fresh dictionary.
  task automatic test_alternating_pattern();
    for (int r = 0; r < 2; r++) begin
      for (int i = 0; i < 7; i++) send_byte((i % 2 == 0) ? 8'hA5 : 8'h5A, i == 6);
    end
  endtask

  task automatic test_random_streams(input int unsigned n_items);
    int unsigned       sent;
    int unsigned       len;
    int unsigned       alpha_n;
    bit                noisy;
    logic [BYTE_W-1:0] alphabet[4];
    logic [BYTE_W-1:0] b;
    sent = 0;
    while (sent < n_items) begin
      len     = $urandom_range(1, 16);
      alpha_n = $urandom_range(1, 4);
      noisy   = ($urandom_range(0, 99) < 20);
      for (int k = 0; k < 4; k++) alphabet[k] = BYTE_W'($urandom);
      for (int i = 0; i < len; i++) begin
        b = noisy ? BYTE_W'($urandom) : alphabet[$urandom_range(0, alpha_n - 1)];
        send_byte(b, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    byte_out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      byte_out_if.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    packed_beat_t want;
    if (!rst && byte_out_if.valid && byte_out_if.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("arrived with nothing expected", byte_out_if.packed_byte, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (byte_out_if.packed_byte !== want.data)
          report_mismatch("packed_byte", byte_out_if.packed_byte, want.data);
        if (byte_out_if.stream_end !== want.last)
          report_mismatch("stream_end", byte_out_if.stream_end, want.last);
      end
      beat_index++;
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst                   = 1'b1;
    byte_in_if.valid      = 1'b0;
    byte_in_if.data_byte  = '0;
    byte_in_if.final_byte = 1'b0;
    mismatch_count        = 0;
    beat_index            = 0;
    send_idle_pct         = 18;
    recv_idle_pct         = 79;
    clear_dictionary();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_single_byte_streams();
    test_two_byte_stream();
    test_repeated_byte();
    test_alternating_pattern();
    test_random_streams(45);

    send_idle_pct = 79;
    recv_idle_pct = 18;
    test_random_streams(45);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_streams(45);

    byte_in_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/lzwc_pkg.sv
sv/lzwc_in_if.sv
sv/lzwc_out_if.sv
sv/lzwc_ram.sv
sv/lzwc_packer.sv
sv/lzw_compressor_12bit_packed_core.sv
sim/tb.sv
